### rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg: shared types, constants and functions of the SHA-256 hasher
// Controller states, datapath command and status records, round constants,
// initial hash words and the sigma functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    BYTE_IN,
    BYTE_MARK,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_t;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] LEN_START     = 6'd56;
  localparam logic [5:0] FILL_LAST     = 6'd63;
  localparam logic [5:0] ROUND_LAST    = 6'd63;
  localparam logic [2:0] WORD_LAST     = 3'd7;

  typedef struct packed {
    logic      write_byte;
    byte_sel_t byte_sel;
    logic      count_len;
    logic      load_work;
    logic      round;
    logic      finish;
    logic      init;
    logic      shift_out;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_at_len;
    logic round_last;
  } dp_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:    k = 32'h428a2f98;
      6'd1:    k = 32'h71374491;
      6'd2:    k = 32'hb5c0fbcf;
      6'd3:    k = 32'he9b5dba5;
      6'd4:    k = 32'h3956c25b;
      6'd5:    k = 32'h59f111f1;
      6'd6:    k = 32'h923f82a4;
      6'd7:    k = 32'hab1c5ed5;
      6'd8:    k = 32'hd807aa98;
      6'd9:    k = 32'h12835b01;
      6'd10:   k = 32'h243185be;
      6'd11:   k = 32'h550c7dc3;
      6'd12:   k = 32'h72be5d74;
      6'd13:   k = 32'h80deb1fe;
      6'd14:   k = 32'h9bdc06a7;
      6'd15:   k = 32'hc19bf174;
      6'd16:   k = 32'he49b69c1;
      6'd17:   k = 32'hefbe4786;
      6'd18:   k = 32'h0fc19dc6;
      6'd19:   k = 32'h240ca1cc;
      6'd20:   k = 32'h2de92c6f;
      6'd21:   k = 32'h4a7484aa;
      6'd22:   k = 32'h5cb0a9dc;
      6'd23:   k = 32'h76f988da;
      6'd24:   k = 32'h983e5152;
      6'd25:   k = 32'ha831c66d;
      6'd26:   k = 32'hb00327c8;
      6'd27:   k = 32'hbf597fc7;
      6'd28:   k = 32'hc6e00bf3;
      6'd29:   k = 32'hd5a79147;
      6'd30:   k = 32'h06ca6351;
      6'd31:   k = 32'h14292967;
      6'd32:   k = 32'h27b70a85;
      6'd33:   k = 32'h2e1b2138;
      6'd34:   k = 32'h4d2c6dfc;
      6'd35:   k = 32'h53380d13;
      6'd36:   k = 32'h650a7354;
      6'd37:   k = 32'h766a0abb;
      6'd38:   k = 32'h81c2c92e;
      6'd39:   k = 32'h92722c85;
      6'd40:   k = 32'ha2bfe8a1;
      6'd41:   k = 32'ha81a664b;
      6'd42:   k = 32'hc24b8b70;
      6'd43:   k = 32'hc76c51a3;
      6'd44:   k = 32'hd192e819;
      6'd45:   k = 32'hd6990624;
      6'd46:   k = 32'hf40e3585;
      6'd47:   k = 32'h106aa070;
      6'd48:   k = 32'h19a4c116;
      6'd49:   k = 32'h1e376c08;
      6'd50:   k = 32'h2748774c;
      6'd51:   k = 32'h34b0bcb5;
      6'd52:   k = 32'h391c0cb3;
      6'd53:   k = 32'h4ed8aa4a;
      6'd54:   k = 32'h5b9cca4f;
      6'd55:   k = 32'h682e6ff3;
      6'd56:   k = 32'h748f82ee;
      6'd57:   k = 32'h78a5636f;
      6'd58:   k = 32'h84c87814;
      6'd59:   k = 32'h8cc70208;
      6'd60:   k = 32'h90befffa;
      6'd61:   k = 32'ha4506ceb;
      6'd62:   k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

### rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher: byte-stream SHA-256 hasher
// Takes message bytes one per word, pads at end of message, emits the digest.
// ----------------------------------------------------------------------------
// A message enters one byte per input word; a word may instead (or also) carry
// the end-of-message flag, so an empty message is fine. While a block fills,
// the block takes one word per cycle. The 64th byte of a block starts the
// compression: the rounds of the single shared round unit, then a step that
// folds the result into the chain words, all with in_stall high. At end
// of message the block appends the 0x80 marker, zeros and the 64-bit length one
// byte per cycle outside the compressions (with one pass-through step at offset
// 56), running one or two further compressions, then presents the eight
// digest words h0 first on the output channel. Input stays stalled until
// the last digest word is taken; the hasher then starts a fresh message.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha256_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller: owns the handshakes and sequences the datapath.
  sha256_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .word_index        (out_word_index),
    .last_word         (out_last_word),
    .stat              (stat),
    .cmd               (cmd)
  );

  // Datapath: block window, schedule, round unit, chain words.
  sha256_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_data_byte),
    .stat        (stat),
    .digest_word (out_digest_word)
  );

  // Never take input while a digest is on offer.
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while digest pending");

  // Taking the last digest word reopens the input.
  a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=> !in_stall)
    else $error("input not reopened after last digest word");

  // Digest words advance one index at a time without a gap.
  a_word_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=>
      (out_valid && (out_word_index == 3'($past(out_word_index) + 3'd1))))
    else $error("digest word index did not advance");

endmodule

### rtl/sha256_dp.sv
// ----------------------------------------------------------------------------
// sha256_dp: SHA-256 datapath
// Block window, message schedule, shared round unit, chain words and length.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha256_pkg::dp_cmd_t  cmd,
  input  logic [7:0]           in_byte,
  output sha256_pkg::dp_stat_t stat,
  output logic [31:0]          digest_word
);
  import sha256_pkg::*;

  logic [31:0] w_r  [16];
  logic [31:0] wk_r [8];
  logic [31:0] h_r  [8];
  logic [5:0]  fill_r;
  logic [63:0] len_r;
  logic [5:0]  rnd_r;

  logic [7:0]  wr_byte;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  // Pick the byte to append; length bytes go out most significant first.
  always_comb begin
    case (cmd.byte_sel)
      BYTE_IN:   wr_byte = in_byte;
      BYTE_MARK: wr_byte = PAD_MARK_BYTE;
      BYTE_ZERO: wr_byte = 8'h00;
      BYTE_LEN:  wr_byte = 8'(len_r >> {~fill_r[2:0], 3'b000});
      default:   wr_byte = 8'h00;
    endcase
  end

  assign w_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  assign ch    = (wk_r[4] & wk_r[5]) ^ (~wk_r[4] & wk_r[6]);
  assign maj   = (wk_r[0] & wk_r[1]) ^ (wk_r[0] & wk_r[2]) ^ (wk_r[1] & wk_r[2]);
  assign t1    = wk_r[7] + bsig1(wk_r[4]) + ch + round_k(rnd_r) + w_r[0];
  assign t2    = bsig0(wk_r[0]) + maj;

  // Block window: bytes land big-endian; during rounds it slides as the schedule.
  always_ff @(posedge clk) begin
    if (cmd.write_byte) begin
      w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= wr_byte;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int i = 0; i < 8; i++) begin
        wk_r[i] <= h_r[i];
      end
    end else if (cmd.round) begin
      wk_r[0] <= t1 + t2;
      wk_r[1] <= wk_r[0];
      wk_r[2] <= wk_r[1];
      wk_r[3] <= wk_r[2];
      wk_r[4] <= wk_r[3] + t1;
      wk_r[5] <= wk_r[4];
      wk_r[6] <= wk_r[5];
      wk_r[7] <= wk_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= iv_word(3'(i));
      end
    end else if (cmd.finish) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= h_r[i] + wk_r[i];
      end
    end else if (cmd.shift_out) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= h_r[3'(i + 1)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      fill_r <= '0;
      len_r  <= '0;
    end else begin
      if (cmd.write_byte) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.count_len) begin
        len_r <= len_r + 64'd8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
    end else if (cmd.round) begin
      rnd_r <= rnd_r + 6'd1;
    end
  end

  assign stat.fill_last   = (fill_r == FILL_LAST);
  assign stat.fill_at_len = (fill_r == LEN_START);
  assign stat.round_last  = (rnd_r == ROUND_LAST);
  assign digest_word      = h_r[0];

endmodule

### rtl/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// sha256_ctrl: SHA-256 controller
// Sequences byte intake, padding, compression and digest delivery.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_byte_valid,
  input  logic                 in_end_of_message,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           word_index,
  output logic                 last_word,
  input  sha256_pkg::dp_stat_t stat,
  output sha256_pkg::dp_cmd_t  cmd
);
  import sha256_pkg::*;

  state_t     state_r, state_nxt;
  state_t     ret_r, ret_nxt;
  logic [2:0] word_r, word_nxt;
  logic       out_acc;

  assign out_acc = (state_r == ST_OUT) && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      word_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      word_r  <= word_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    word_nxt  = out_acc ? word_r + 3'd1 : word_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_byte_valid && stat.fill_last) begin
            state_nxt = ST_ROUND;
            ret_nxt   = in_end_of_message ? ST_PAD_MARK : ST_IDLE;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD_MARK;
          end
        end
      end
      ST_PAD_MARK: begin
        if (stat.fill_last) begin
          state_nxt = ST_ROUND;
          ret_nxt   = ST_PAD_ZERO;
        end else begin
          state_nxt = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (stat.fill_at_len) begin
          state_nxt = ST_PAD_LEN;
        end else if (stat.fill_last) begin
          state_nxt = ST_ROUND;
          ret_nxt   = ST_PAD_ZERO;
        end
      end
      ST_PAD_LEN: begin
        if (stat.fill_last) begin
          state_nxt = ST_ROUND;
          ret_nxt   = ST_OUT;
        end
      end
      ST_ROUND: begin
        if (stat.round_last) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        state_nxt = ret_r;
      end
      ST_OUT: begin
        if (out_acc && word_r == WORD_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd          = '0;
    cmd.byte_sel = BYTE_IN;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.write_byte = in_valid && in_byte_valid;
        cmd.count_len  = in_valid && in_byte_valid;
        cmd.load_work  = in_valid && in_byte_valid && stat.fill_last;
      end
      ST_PAD_MARK: begin
        cmd.write_byte = 1'b1;
        cmd.byte_sel   = BYTE_MARK;
        cmd.load_work  = stat.fill_last;
      end
      ST_PAD_ZERO: begin
        cmd.write_byte = !stat.fill_at_len;
        cmd.byte_sel   = BYTE_ZERO;
        cmd.load_work  = !stat.fill_at_len && stat.fill_last;
      end
      ST_PAD_LEN: begin
        cmd.write_byte = 1'b1;
        cmd.byte_sel   = BYTE_LEN;
        cmd.load_work  = stat.fill_last;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
      end
      ST_FINAL: begin
        cmd.finish = 1'b1;
      end
      ST_OUT: begin
        out_valid     = 1'b1;
        cmd.shift_out = out_acc;
        cmd.init      = out_acc && (word_r == WORD_LAST);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign word_index = word_r;
  assign last_word  = (word_r == WORD_LAST);

endmodule
